[sv/deq_pkg.sv]
`default_nettype none

package deq_pkg;

    // Width of one stored word
    localparam int unsigned WORD_W = 32;

    // Operation codes carried by kind
    localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [1:0] KIND_POP_FRONT  = 2'd1;
    localparam logic [1:0] KIND_PUSH_BACK  = 2'd2;
    localparam logic [1:0] KIND_POP_BACK   = 2'd3;

    // Word returned on pushes and on pops of an empty queue
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

    typedef logic signed [WORD_W-1:0] word_t;

    // Command broadcast to every cell for one transfer
    typedef struct packed {
        logic shift_in;   // push front: take the left neighbor's word
        logic shift_out;  // pop front: take the right neighbor's word
        logic put_back;   // push back: first free cell stores the new word
        logic drop_back;  // pop back: last occupied cell empties
    } cell_cmd_t;

endpackage

`default_nettype wire

[sv/double_ended_queue_core.sv]
`default_nettype none

// Channel | Handshake           | Payload
// --------+---------------------+-------------------------------
// in      | in_valid / in_ready | kind[1:0], value[31:0] signed
// out     | out_valid/out_ready | popped[31:0] signed, was_empty, was_full
//
// One item per cycle unless stalled: the cell row updates in the transfer
// cycle and the result appears in the output register on the next cycle.
// The front word sits in cell 0; the back word is picked from the one cell
// flagged as last occupied, an OR across all DEPTH cells.
// Reset empties every cell at once; stored words are not cleared.
// in_ready drops only while a result is held and out_ready is low.

module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 32
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  kind,
    input  word_t       value,
    output logic        out_valid,
    input  wire         out_ready,
    output word_t       popped,
    output logic        was_empty,
    output logic        was_full
);

    word_t     cell_data  [DEPTH];
    logic      cell_valid [DEPTH];
    logic      cell_tail  [DEPTH];
    cell_cmd_t cmd;
    logic      in_xfer;
    logic      is_full;
    logic      is_empty;
    word_t     back_word;

    logic      out_valid_reg;
    logic      out_valid_next;
    word_t     popped_reg;
    word_t     popped_next;
    logic      was_empty_reg;
    logic      was_empty_next;
    logic      was_full_reg;
    logic      was_full_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;
    assign is_empty = !cell_valid[0];
    assign is_full  = cell_valid[DEPTH-1];

    // Command decode for the cell row
    always_comb
    begin
        cmd = '0;
        if (in_xfer)
        begin
            unique case (kind)
                KIND_PUSH_FRONT: cmd.shift_in  = !is_full;
                KIND_POP_FRONT:  cmd.shift_out = !is_empty;
                KIND_PUSH_BACK:  cmd.put_back  = !is_full;
                KIND_POP_BACK:   cmd.drop_back = !is_empty;
                default:         cmd = '0;
            endcase
        end
    end

    // Row of cells, front at index 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t left_data;
        logic  left_valid;
        word_t right_data;
        logic  right_valid;

        if (i == 0)
        begin : g_front
            assign left_data  = value;
            assign left_valid = 1'b1;
        end
        else
        begin : g_inner_l
            assign left_data  = cell_data[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner_r
            assign right_data  = cell_data[i+1];
            assign right_valid = cell_valid[i+1];
        end

        deq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .new_word    (value),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .right_data  (right_data),
            .right_valid (right_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .tail        (cell_tail[i])
        );
    end

    // Back word: only the last occupied cell raises its tail flag
    always_comb
    begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_word = back_word | (cell_tail[i] ? cell_data[i] : '0);
        end
    end

    // Result for the current transfer
    always_comb
    begin
        popped_next    = popped_reg;
        was_empty_next = was_empty_reg;
        was_full_next  = was_full_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
            popped_next    = EMPTY_WORD;
            was_empty_next = 1'b0;
            was_full_next  = 1'b0;
            unique case (kind)
                KIND_PUSH_FRONT, KIND_PUSH_BACK:
                begin
                    was_full_next = is_full;
                end
                KIND_POP_FRONT:
                begin
                    was_empty_next = is_empty;
                    if (!is_empty)
                    begin
                        popped_next = cell_data[0];
                    end
                end
                KIND_POP_BACK:
                begin
                    was_empty_next = is_empty;
                    if (!is_empty)
                    begin
                        popped_next = back_word;
                    end
                end
                default:
                begin
                    popped_next = EMPTY_WORD;
                end
            endcase
        end
    end

    // Output handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        popped_reg    <= popped_next;
        was_empty_reg <= was_empty_next;
        was_full_reg  <= was_full_next;
    end

    assign out_valid = out_valid_reg;
    assign popped    = popped_reg;
    assign was_empty = was_empty_reg;
    assign was_full  = was_full_reg;

endmodule

`default_nettype wire

[sv/deq_cell.sv]
`default_nettype none

module deq_cell
    import deq_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  cell_cmd_t  cmd,
    input  word_t      new_word,
    input  word_t      left_data,
    input  wire        left_valid,
    input  word_t      right_data,
    input  wire        right_valid,
    output word_t      data,
    output logic       valid,
    output logic       tail
);

    word_t data_reg;
    word_t data_next;
    logic  valid_reg;
    logic  valid_next;

    // Next contents: shift either way, or act as the back end
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (cmd.shift_in)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (cmd.shift_out)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (cmd.put_back && left_valid && !valid_reg)
        begin
            data_next  = new_word;
            valid_next = 1'b1;
        end
        else if (cmd.drop_back && valid_reg && !right_valid)
        begin
            valid_next = 1'b0;
        end
    end

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stored word, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign tail  = valid_reg && !right_valid;

endmodule

`default_nettype wire
